>>> rtl/gss_pkg.sv
// Shared types and constants for the golden-section search controller.
package gss_pkg;

  // Golden ratio weight r = (sqrt(5) - 1) / 2 as unsigned Q0.32.
  localparam logic [31:0] GOLD_R = 32'h9E37_79B9;

  // Half of one LSB of the Q0.32 product, used for round half up.
  localparam logic [65:0] ROUND_HALF = 66'h0_8000_0000;

  localparam int unsigned ITER_W = 10;
  localparam logic [ITER_W-1:0] ITER_RESET = 10'd32;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  localparam logic [1:0] STATUS_QUERY   = 2'd0;
  localparam logic [1:0] STATUS_DONE    = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] bound_low;
    logic signed [31:0] bound_high;
    logic signed [31:0] function_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] point;
    logic signed [31:0] min_value;
  } out_word_t;

endpackage

>>> rtl/golden_section_search.sv
// Golden-section minimum search controller, Q16.16 fixed point.
//
// The input channel (in_valid, in_stall, in_data) carries two kinds of word.
// A start word brings the interval ends and restarts any search in progress.
// A value word returns the objective value at the last point that was asked
// for. Every input word produces exactly one output word on the output
// channel (out_valid, out_stall, out_data): a query point, the final best
// point with its value, or an ignored status for a value word while idle.
// The iteration count is written through the cfg channel (cfg_valid,
// cfg_ready, cfg_data); the port is always ready and should only be used
// while the block is idle.
//
// An accepted input word passes through the input register, then through the
// update logic into the result register. Throughput is one word per cycle
// while the output does not stall; the single 33x33 constant multiply that
// places the new interior point is combinational in the update logic.
// Reset clears the search state, sets the iteration count to 32 and empties
// both registers. When the receiver stalls, the result register holds its
// word, one more word can wait in the input register, and then in_stall
// rises until the output drains.
module golden_section_search
  import gss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ITER_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST_LEFT,
    PH_FIRST_RIGHT,
    PH_ITER
  } phase_t;

  // Configuration.
  logic [ITER_W-1:0] iteration_count;

  // Input register.
  logic     in_reg_valid;
  in_word_t in_reg;

  // Search state.
  phase_t            phase, phase_next;
  logic [31:0]       left_end, left_end_next;
  logic [31:0]       right_end, right_end_next;
  logic [31:0]       inner_left, inner_left_next;
  logic [31:0]       inner_right, inner_right_next;
  logic [31:0]       value_left, value_left_next;
  logic [31:0]       value_right, value_right_next;
  logic [ITER_W-1:0] iterations_done, iterations_done_next;
  logic              pending_is_left, pending_is_left_next;

  out_word_t res_next;

  // The item in the input register moves on whenever the result register
  // is empty or is being emptied in this cycle.
  logic fire;
  assign fire     = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !fire;
  assign cfg_ready = 1'b1;

  // Values and count as they stand once this value word is taken in.
  logic [31:0]       eff_left, eff_right;
  logic [ITER_W-1:0] eff_done;
  logic              finished, drop_left;

  always_comb begin
    eff_left  = value_left;
    eff_right = value_right;
    eff_done  = iterations_done;
    case (phase)
      PH_FIRST_RIGHT: begin
        eff_right = in_reg.function_value;
        eff_done  = '0;
      end
      PH_ITER: begin
        if (pending_is_left) begin
          eff_left = in_reg.function_value;
        end else begin
          eff_right = in_reg.function_value;
        end
        eff_done = iterations_done + ITER_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign finished  = eff_done >= iteration_count;
  assign drop_left = $signed(eff_left) > $signed(eff_right);

  // A new point is base + r * (other - base), rounded half up. This equals
  // the weighted sum r*other + (1-r)*base because the two weights sum to one.
  logic [31:0]        mix_base, mix_other;
  logic signed [32:0] mix_diff;
  logic signed [65:0] mix_prod;
  logic [65:0]        mix_round;
  logic [31:0]        mix_point;

  always_comb begin
    if (in_reg.kind == KIND_START) begin
      mix_base  = in_reg.bound_high;
      mix_other = in_reg.bound_low;
    end else if (phase == PH_FIRST_LEFT) begin
      mix_base  = left_end;
      mix_other = right_end;
    end else if (drop_left) begin
      // The left part goes: the new left end is the old left interior point.
      mix_base  = inner_left;
      mix_other = right_end;
    end else begin
      mix_base  = inner_right;
      mix_other = left_end;
    end
  end

  assign mix_diff  = $signed({mix_other[31], mix_other}) - $signed({mix_base[31], mix_base});
  assign mix_prod  = $signed({1'b0, GOLD_R}) * mix_diff;
  assign mix_round = mix_prod + ROUND_HALF;
  assign mix_point = mix_base + mix_round[63:32];

  always_comb begin
    phase_next           = phase;
    left_end_next        = left_end;
    right_end_next       = right_end;
    inner_left_next      = inner_left;
    inner_right_next     = inner_right;
    value_left_next      = value_left;
    value_right_next     = value_right;
    iterations_done_next = iterations_done;
    pending_is_left_next = pending_is_left;
    res_next.status      = STATUS_QUERY;
    res_next.point       = '0;
    res_next.min_value   = '0;

    if (in_reg.kind == KIND_START) begin
      left_end_next        = in_reg.bound_low;
      right_end_next       = in_reg.bound_high;
      inner_left_next      = mix_point;
      iterations_done_next = '0;
      pending_is_left_next = 1'b1;
      phase_next           = PH_FIRST_LEFT;
      res_next.point       = mix_point;
    end else begin
      case (phase)
        PH_FIRST_LEFT: begin
          // The right interior point is placed only now, when it is asked for.
          value_left_next      = in_reg.function_value;
          inner_right_next     = mix_point;
          pending_is_left_next = 1'b0;
          phase_next           = PH_FIRST_RIGHT;
          res_next.point       = mix_point;
        end
        PH_FIRST_RIGHT, PH_ITER: begin
          value_left_next      = eff_left;
          value_right_next     = eff_right;
          iterations_done_next = eff_done;
          if (finished) begin
            phase_next      = PH_IDLE;
            res_next.status = STATUS_DONE;
            if ($signed(eff_left) < $signed(eff_right)) begin
              res_next.point     = inner_left;
              res_next.min_value = eff_left;
            end else begin
              res_next.point     = inner_right;
              res_next.min_value = eff_right;
            end
          end else begin
            phase_next     = PH_ITER;
            res_next.point = mix_point;
            if (drop_left) begin
              left_end_next        = inner_left;
              inner_left_next      = inner_right;
              value_left_next      = eff_right;
              inner_right_next     = mix_point;
              pending_is_left_next = 1'b0;
            end else begin
              right_end_next       = inner_right;
              inner_right_next     = inner_left;
              value_right_next     = eff_left;
              inner_left_next      = mix_point;
              pending_is_left_next = 1'b1;
            end
          end
        end
        default: begin
          res_next.status = STATUS_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= ITER_RESET;
      in_reg_valid    <= 1'b0;
      out_valid       <= 1'b0;
      phase           <= PH_IDLE;
      left_end        <= '0;
      right_end       <= '0;
      inner_left      <= '0;
      inner_right     <= '0;
      value_left      <= '0;
      value_right     <= '0;
      iterations_done <= '0;
      pending_is_left <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        iteration_count <= cfg_data;
      end

      if (!in_stall) begin
        in_reg_valid <= in_valid;
        in_reg       <= in_data;
      end

      if (fire) begin
        out_valid       <= 1'b1;
        out_data        <= res_next;
        phase           <= phase_next;
        left_end        <= left_end_next;
        right_end       <= right_end_next;
        inner_left      <= inner_left_next;
        inner_right     <= inner_right_next;
        value_left      <= value_left_next;
        value_right     <= value_right_next;
        iterations_done <= iterations_done_next;
        pending_is_left <= pending_is_left_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
